@@ hw/rtl/ntpc_pkg.sv @@
// Shared types and constants for the NTP seconds to calendar converter.
package ntpc_pkg;

	localparam int unsigned SECS_BIAS    = 604800;  // one week, keeps the sum positive
	localparam int unsigned DAY_RECIP    = 99420;   // floor(2^26 / 675)
	localparam int unsigned WEEK_RECIP   = 18724;   // floor(2^17 / 7)
	localparam int unsigned HOUR_RECIP   = 36;      // floor(2^13 / 225)
	localparam int unsigned QUAD_RECIP   = 44;      // floor(2^16 / 1461)
	localparam int unsigned MIN_RECIP    = 68;      // floor(2^10 / 15)
	localparam int unsigned DAYS_TO_2000 = 36531;   // including the week of bias
	localparam int unsigned DAYS_CENTURY = 36525;

	typedef struct packed {
		logic [6:0] year_since_2000;
		logic [3:0] month;
		logic [4:0] day_of_month;
		logic [2:0] weekday;
		logic [4:0] hours;
		logic [5:0] minutes;
		logic [5:0] seconds;
		logic       out_of_range;
	} cal_t;

	// first day of month idx (0 = January), counted from the start of the year
	function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
		logic [8:0] s;
		case (idx)
			4'd0:    s = 9'd0;
			4'd1:    s = 9'd31;
			4'd2:    s = 9'd59;
			4'd3:    s = 9'd90;
			4'd4:    s = 9'd120;
			4'd5:    s = 9'd151;
			4'd6:    s = 9'd181;
			4'd7:    s = 9'd212;
			4'd8:    s = 9'd243;
			4'd9:    s = 9'd273;
			4'd10:   s = 9'd304;
			4'd11:   s = 9'd334;
			default: s = 9'd0;
		endcase
		if (leap && idx >= 4'd2) begin
			s = s + 9'd1;
		end
		return s;
	endfunction

endpackage

@@ hw/rtl/ntp_seconds_to_calendar.sv @@
// Converts an NTP seconds count plus a local offset into local date and time.
// Eight-stage pipeline: one transfer may enter every cycle, and a stall on the
// output holds the whole pipeline.
// Stage 1 adds the offset, stages 2-3 split days from the second of day by a
// reciprocal multiply, stages 4-8 derive weekday, time of day and the date.
// Years outside 2000..2099 set the tuser flag and zero year, month and day.
module ntp_seconds_to_calendar (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [16:0] cfg_wdata,      // utc_offset_seconds, signed
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // ntp_seconds
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// year_since_2000[6:0], month[10:7], day_of_month[15:11], weekday[18:16],
	// hours[23:19], minutes[29:24], seconds[35:30], zero fill [39:36]
	output logic [39:0] m_axis_tdata,
	output logic [0:0]  m_axis_tuser    // out_of_range
);
	import ntpc_pkg::*;

	logic signed [16:0] offset_q;
	logic               en;
	logic               v_s1;
	logic [32:0]        secs_s1;
	logic               v_days;
	logic [16:0]        days;
	logic [16:0]        tod;
	cal_t               cal;

	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= 17'sd3600;
		end else if (cfg_we) begin
			offset_q <= signed'(cfg_wdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	// sum is always positive once the week of bias is added
	always_ff @(posedge clk) begin
		if (en) begin
			secs_s1 <= 33'(s_axis_tdata) + 33'(offset_q) + 33'(SECS_BIAS);
		end
	end

	ntpc_day_split u_day_split (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_in   (v_s1),
		.secs   (secs_s1),
		.v_out  (v_days),
		.days   (days),
		.tod    (tod)
	);

	ntpc_calendar u_calendar (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_in   (v_days),
		.days   (days),
		.tod    (tod),
		.v_out  (m_axis_tvalid),
		.cal    (cal)
	);

	assign m_axis_tdata = {4'd0, cal.seconds, cal.minutes, cal.hours, cal.weekday,
		cal.day_of_month, cal.month, cal.year_since_2000};
	assign m_axis_tuser = cal.out_of_range;

endmodule

@@ hw/rtl/ntpc_day_split.sv @@
// Splits biased seconds into day count and second of day (two stages).
module ntpc_day_split (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        v_in,
	input  logic [32:0] secs,
	output logic        v_out,
	output logic [16:0] days,
	output logic [16:0] tod
);
	import ntpc_pkg::*;

	logic [42:0] prod;
	logic [25:0] q1_s2;
	logic [6:0]  lo_s2;
	logic [16:0] qe_s2;
	logic        v_s2;

	logic [26:0] back;
	logic [10:0] r;
	logic [16:0] days_n;
	logic [9:0]  rr;
	logic [16:0] days_s3;
	logic [16:0] tod_s3;
	logic        v_s3;

	// 86400 = 128 * 675: shift off the 128, then reciprocal estimate for 675
	assign prod = 43'(secs[32:7]) * 43'(DAY_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q1_s2 <= secs[32:7];
			lo_s2 <= secs[6:0];
			qe_s2 <= prod[42:26];
		end
	end

	always_comb begin
		back = 27'(qe_s2) * 27'd675;
		r = 11'(27'(q1_s2) - back);
		if (r >= 11'd675) begin
			days_n = qe_s2 + 17'd1;
			rr = 10'(r - 11'd675);
		end else begin
			days_n = qe_s2;
			rr = r[9:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			days_s3 <= days_n;
			tod_s3  <= {rr, lo_s2};
		end
	end

	assign v_out = v_s3;
	assign days  = days_s3;
	assign tod   = tod_s3;

endmodule

@@ hw/rtl/ntpc_calendar.sv @@
// Day count and second of day to weekday, date and time of day (five stages).
module ntpc_calendar (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                v_in,
	input  logic [16:0]         days,
	input  logic [16:0]         tod,
	output logic                v_out,
	output ntpc_pkg::cal_t      cal
);
	import ntpc_pkg::*;

	// stage 4: reciprocal estimates
	logic [31:0] wprod;
	logic [18:0] hprod;
	logic [21:0] qprod;
	logic [15:0] d_n;
	logic        oor_n;
	logic        v_s4, oor_s4;
	logic [16:0] days_s4, tod_s4;
	logic [14:0] wq_s4;
	logic [5:0]  he_s4, qe_s4;
	logic [15:0] d_s4;

	// stage 5: corrections
	logic [3:0]  wr;
	logic [2:0]  wd_n;
	logic [12:0] hr;
	logic [4:0]  h_n;
	logic [11:0] remh_n;
	logic [11:0] qr;
	logic [4:0]  quad_n;
	logic [10:0] qrem_n;
	logic        v_s5, oor_s5;
	logic [2:0]  wd_s5;
	logic [4:0]  h_s5, quad_s5;
	logic [11:0] remh_s5;
	logic [10:0] qrem_s5;

	// stage 6: minute estimate, year within the four-year block
	logic [16:0] mprod;
	logic [10:0] r2;
	logic [1:0]  yinq;
	logic [8:0]  yrem_n;
	logic        v_s6, oor_s6, leap_s6;
	logic [2:0]  wd_s6;
	logic [4:0]  h_s6;
	logic [11:0] remh_s6;
	logic [5:0]  me_s6;
	logic [6:0]  year_s6;
	logic [8:0]  yrem_s6;

	// stage 7: minutes, seconds, month index
	logic [6:0]  rs;
	logic [5:0]  min_n, sec_n;
	logic [3:0]  cnt;
	logic        v_s7, oor_s7, leap_s7;
	logic [2:0]  wd_s7;
	logic [4:0]  h_s7;
	logic [5:0]  min_s7, sec_s7;
	logic [6:0]  year_s7;
	logic [8:0]  yrem_s7;
	logic [3:0]  cnt_s7;

	// stage 8: output register
	logic [8:0]  mday;
	logic        v_s8;
	cal_t        cal_s8;

	always_comb begin
		wprod = 32'(days) * 32'(WEEK_RECIP);
		hprod = 19'(tod[16:4]) * 19'(HOUR_RECIP);
		d_n   = 16'(days - 17'(DAYS_TO_2000));
		oor_n = (days < 17'(DAYS_TO_2000)) || (days >= 17'(DAYS_TO_2000 + DAYS_CENTURY));
		qprod = 22'(d_n) * 22'(QUAD_RECIP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_in;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			days_s4 <= days;
			tod_s4  <= tod;
			wq_s4   <= wprod[31:17];
			he_s4   <= hprod[18:13];
			d_s4    <= d_n;
			qe_s4   <= qprod[21:16];
			oor_s4  <= oor_n;
		end
	end

	always_comb begin
		wr = 4'(days_s4 - 17'(wq_s4) * 17'd7);
		wd_n = (wr >= 4'd7) ? 3'(wr - 4'd7) : wr[2:0];
		hr = 13'(tod_s4 - 17'(he_s4) * 17'd3600);
		if (hr >= 13'd3600) begin
			h_n = 5'(he_s4 + 6'd1);
			remh_n = 12'(hr - 13'd3600);
		end else begin
			h_n = he_s4[4:0];
			remh_n = hr[11:0];
		end
		qr = 12'(d_s4 - 16'(qe_s4) * 16'd1461);
		if (qr >= 12'd1461) begin
			quad_n = 5'(qe_s4 + 6'd1);
			qrem_n = 11'(qr - 12'd1461);
		end else begin
			quad_n = qe_s4[4:0];
			qrem_n = qr[10:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wd_s5   <= wd_n;
			h_s5    <= h_n;
			remh_s5 <= remh_n;
			quad_s5 <= quad_n;
			qrem_s5 <= qrem_n;
			oor_s5  <= oor_s4;
		end
	end

	always_comb begin
		mprod = 17'(remh_s5[11:2]) * 17'(MIN_RECIP);
		r2 = qrem_s5 - 11'd366;
		if (qrem_s5 < 11'd366) begin
			yinq = 2'd0;
			yrem_n = qrem_s5[8:0];
		end else if (r2 >= 11'd730) begin
			yinq = 2'd3;
			yrem_n = 9'(r2 - 11'd730);
		end else if (r2 >= 11'd365) begin
			yinq = 2'd2;
			yrem_n = 9'(r2 - 11'd365);
		end else begin
			yinq = 2'd1;
			yrem_n = r2[8:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wd_s6   <= wd_s5;
			h_s6    <= h_s5;
			remh_s6 <= remh_s5;
			me_s6   <= mprod[15:10];
			year_s6 <= {quad_s5, yinq};
			yrem_s6 <= yrem_n;
			leap_s6 <= (yinq == 2'd0);
			oor_s6  <= oor_s5;
		end
	end

	always_comb begin
		rs = 7'(remh_s6 - 12'(me_s6) * 12'd60);
		if (rs >= 7'd60) begin
			min_n = me_s6 + 6'd1;
			sec_n = 6'(rs - 7'd60);
		end else begin
			min_n = me_s6;
			sec_n = rs[5:0];
		end
		cnt = 4'd0;
		for (int k = 1; k < 12; k++) begin
			cnt = cnt + 4'(yrem_s6 >= month_start(4'(k), leap_s6));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wd_s7   <= wd_s6;
			h_s7    <= h_s6;
			min_s7  <= min_n;
			sec_s7  <= sec_n;
			year_s7 <= year_s6;
			yrem_s7 <= yrem_s6;
			leap_s7 <= leap_s6;
			cnt_s7  <= cnt;
			oor_s7  <= oor_s6;
		end
	end

	assign mday = yrem_s7 - month_start(cnt_s7, leap_s7) + 9'd1;

	always_ff @(posedge clk) begin
		if (en) begin
			cal_s8.year_since_2000 <= oor_s7 ? 7'd0 : year_s7;
			cal_s8.month           <= oor_s7 ? 4'd0 : cnt_s7 + 4'd1;
			cal_s8.day_of_month    <= oor_s7 ? 5'd0 : mday[4:0];
			cal_s8.weekday         <= wd_s7 + 3'd1;
			cal_s8.hours           <= h_s7;
			cal_s8.minutes         <= min_s7;
			cal_s8.seconds         <= sec_s7;
			cal_s8.out_of_range    <= oor_s7;
		end
	end

	assign v_out = v_s8;
	assign cal   = cal_s8;

endmodule

@@ hw/rtl/ntpc_checker.sv @@
// Port-level checks for the converter, bound to the top level.
module ntpc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic [0:0]  m_axis_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("output changed while stalled");

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[15:0] == 16'd0)
		else $error("out of range result carries a date");

	a_date: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[6:0] < 7'd100
			&& m_axis_tdata[10:7] != 4'd0 && m_axis_tdata[10:7] < 4'd13
			&& m_axis_tdata[15:11] != 5'd0)
		else $error("date field out of range");

	a_time: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[18:16] != 3'd0 && m_axis_tdata[23:19] < 5'd24
			&& m_axis_tdata[29:24] < 6'd60 && m_axis_tdata[35:30] < 6'd60
			&& m_axis_tdata[39:36] == 4'd0)
		else $error("weekday or time field out of range");

endmodule

bind ntp_seconds_to_calendar ntpc_checker u_ntpc_checker (.*);
